// ----- rtl/psa_pkg.sv -----
// ----------------------------------------------------------------------------
// psa_pkg: shared types and constants for the priority scheduler with aging
// Table sizes, request codes, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package psa_pkg;

    localparam int MAX_PROCS  = 16;
    localparam int MAX_IO_OPS = 4;
    localparam int PW         = $clog2(MAX_PROCS);
    localparam int SW         = $clog2(MAX_IO_OPS);
    localparam int IOW        = PW + SW;
    localparam int CW         = $clog2(MAX_PROCS + 1);

    localparam logic [1:0] REQ_LOAD_PROC = 2'd0;
    localparam logic [1:0] REQ_LOAD_IO   = 2'd1;
    localparam logic [1:0] REQ_ROUND     = 2'd2;

    localparam logic [1:0] REG_QUANTUM   = 2'd0;
    localparam logic [1:0] REG_AGING     = 2'd1;
    localparam logic [1:0] REG_MAX_PRIO  = 2'd2;
    localparam logic [1:0] REG_PROC_CNT  = 2'd3;

    // Per-process record held in one memory word.
    typedef struct packed {
        logic [15:0] arrival;
        logic [7:0]  prio;
        logic [15:0] remaining;
        logic [15:0] executed;
        logic [15:0] wait_cnt;
        logic        blocked;
        logic [15:0] countdown;
        logic [2:0]  io_pos;
        logic [2:0]  io_cnt;
        logic        done;
    } proc_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ALL_DONE,
        ST_SCAN_RD,
        ST_SCAN,
        ST_AGE_RD,
        ST_AGE,
        ST_PICK_RD,
        ST_IO_RD,
        ST_RUN,
        ST_EMIT
    } state_t;

endpackage

// ----- rtl/priority_scheduler_with_aging_unit.sv -----
// ----------------------------------------------------------------------------
// priority_scheduler_with_aging_unit: preemptive priority scheduler with aging
//
// Use: write registers on the cfg channel (cfg_valid/cfg_ready, cfg_index,
// cfg_data) while idle. Issue a request with start while busy is low:
// req_type 0 loads a process entry, 1 loads one I/O operation, 2 runs a
// scheduling round. Loads leave busy low and give no result. A round
// gives exactly one result, shown for one cycle with result_valid high.
// Unless all active entries are finished, a round makes two passes over
// the active entries of the process memory (the count register, capped at
// sixteen), one entry per cycle through its single read port: the first
// pass releases I/O and selects, the second ages and writes back.
// One request is in flight at a time; busy stays high through the cycle the
// result shows, except for an all-done round, whose result shows once busy
// is low again.
// Reset returns registers to quantum 2, aging interval 5, max priority 15,
// process count 16, clears time and finished count. The receiver cannot
// stall: the result is taken in the cycle it is shown.
// ----------------------------------------------------------------------------
module priority_scheduler_with_aging_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [3:0]  proc_index,
    input  logic [1:0]  io_slot,
    input  logic [15:0] arrival,
    input  logic [15:0] burst,
    input  logic [7:0]  start_priority,
    input  logic [2:0]  io_total,
    input  logic [15:0] io_start,
    input  logic [15:0] io_duration,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        result_valid,
    output logic        idle,
    output logic [3:0]  chosen,
    output logic [31:0] slice_start,
    output logic [15:0] slice_length,
    output logic        io_began,
    output logic [15:0] io_length,
    output logic        completed,
    output logic        all_done
);
    import psa_pkg::*;

    // process memory, I/O memory
    proc_t       pmem [MAX_PROCS];
    logic [31:0] iomem [MAX_PROCS*MAX_IO_OPS];
    logic        pvalid_reg [MAX_PROCS];

    state_t state_reg, state_next;
    logic [15:0] quantum_reg;
    logic [15:0] aging_reg;
    logic [7:0]  maxp_reg;
    logic [4:0]  pcnt_reg;
    logic [31:0] time_reg;
    logic [CW-1:0] done_cnt_reg;
    logic [CW-1:0] idx_reg;
    logic [PW-1:0] pick_reg;
    logic          found_reg;
    logic [7:0]    best_reg;
    proc_t         rd_reg;
    logic [31:0]   iord_reg;
    proc_t         pk_reg;

    logic [CW-1:0] n_act;
    assign n_act = (pcnt_reg > 5'(MAX_PROCS)) ? CW'(MAX_PROCS) : CW'(pcnt_reg);

    // memory port control
    logic          rd_en, wr_en;
    logic [PW-1:0] rd_addr, wr_addr;
    proc_t         wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            pmem[wr_addr] <= wr_data;
        if (rd_en)
            rd_reg <= pmem[rd_addr];
        if (start && !busy && req_type == REQ_LOAD_IO)
            iomem[{proc_index, io_slot}] <= {io_start, io_duration};
        iord_reg <= iomem[{pick_reg, pk_reg.io_pos[SW-1:0]}];
    end

    // entry as seen after the I/O release step
    proc_t rel;
    always_comb
    begin
        rel = rd_reg;
        if (rd_reg.blocked)
        begin
            if (rd_reg.countdown <= 16'd1)
            begin
                rel.countdown = '0;
                rel.blocked   = 1'b0;
                if (rd_reg.io_pos < 3'd7)
                    rel.io_pos = rd_reg.io_pos + 3'd1;
            end
            else
                rel.countdown = rd_reg.countdown - 16'd1;
        end
    end

    logic ready_ent;
    assign ready_ent = !rel.done && !rel.blocked && ({16'd0, rel.arrival} <= time_reg);

    // aging of the entry read in the second pass (release already applied)
    proc_t aged;
    logic [15:0] w1;
    always_comb
    begin
        aged = rd_reg;
        w1   = (rd_reg.wait_cnt != 16'hFFFF) ? rd_reg.wait_cnt + 16'd1 : rd_reg.wait_cnt;
        if (!(found_reg && idx_reg[PW-1:0] == pick_reg) && !rd_reg.done && !rd_reg.blocked
            && ({16'd0, rd_reg.arrival} <= time_reg))
        begin
            aged.wait_cnt = w1;
            if (w1 >= aging_reg)
            begin
                if (rd_reg.prio < maxp_reg)
                    aged.prio = rd_reg.prio + 8'd1;
                aged.wait_cnt = '0;
            end
        end
    end

    // slice computation on the picked entry
    logic [15:0] run, actual, ioln;
    logic        iob;
    proc_t       fin;
    always_comb
    begin
        run    = (quantum_reg < pk_reg.remaining) ? quantum_reg : pk_reg.remaining;
        actual = run;
        iob    = 1'b0;
        ioln   = '0;
        if (pk_reg.io_pos < pk_reg.io_cnt && pk_reg.io_pos < 3'(MAX_IO_OPS))
        begin
            if (iord_reg[31:16] > pk_reg.executed
                && (iord_reg[31:16] - pk_reg.executed) <= run)
            begin
                actual = iord_reg[31:16] - pk_reg.executed;
                iob    = 1'b1;
                ioln   = iord_reg[15:0];
            end
        end
        fin           = pk_reg;
        fin.remaining = pk_reg.remaining - actual;
        fin.executed  = pk_reg.executed + actual;
        fin.wait_cnt  = '0;
        if (iob)
        begin
            fin.blocked   = 1'b1;
            fin.countdown = ioln;
        end
        fin.done = (fin.remaining == 16'd0);
    end

    logic ld_proc;
    assign ld_proc = start && !busy && req_type == REQ_LOAD_PROC;

    // done flags mirrored in flip-flops for the reload bookkeeping
    logic done_ff_reg [MAX_PROCS];
    function automatic logic pk_done_flag(input logic [PW-1:0] a);
        return done_ff_reg[a];
    endfunction

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (start && req_type == REQ_ROUND)
                    state_next = (done_cnt_reg >= n_act) ? ST_ALL_DONE : ST_SCAN_RD;
            ST_ALL_DONE: state_next = ST_IDLE;
            ST_SCAN_RD:  state_next = ST_SCAN;
            ST_SCAN:     state_next = (idx_reg + CW'(1) >= n_act) ? ST_AGE_RD : ST_SCAN;
            ST_AGE_RD:   state_next = ST_AGE;
            ST_AGE:
                if (idx_reg + CW'(1) >= n_act)
                    state_next = found_reg ? ST_PICK_RD : ST_EMIT;
            ST_PICK_RD:  state_next = ST_IO_RD;
            ST_IO_RD:    state_next = ST_RUN;
            ST_RUN:      state_next = ST_EMIT;
            ST_EMIT:     state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // memory port outputs
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = idx_reg[PW-1:0];
        wr_en   = 1'b0;
        wr_addr = idx_reg[PW-1:0];
        wr_data = rel;
        case (state_reg)
            ST_IDLE:
            begin
                rd_en   = 1'b1;
                rd_addr = '0;
                if (ld_proc)
                begin
                    wr_en   = 1'b1;
                    wr_addr = proc_index;
                    wr_data = '{arrival: arrival, prio: start_priority, remaining: burst,
                                executed: '0, wait_cnt: '0, blocked: 1'b0, countdown: '0,
                                io_pos: '0,
                                io_cnt: (io_total > 3'(MAX_IO_OPS)) ? 3'(MAX_IO_OPS) : io_total,
                                done: 1'b0};
                end
            end
            ST_SCAN:
            begin
                // write back release, prefetch the next entry
                wr_en   = 1'b1;
                rd_en   = 1'b1;
                rd_addr = idx_reg[PW-1:0] + PW'(1);
                if (idx_reg + CW'(1) >= n_act)
                    rd_addr = '0;
            end
            ST_AGE_RD, ST_SCAN_RD: rd_en = 1'b1;
            ST_AGE:
            begin
                wr_en   = 1'b1;
                wr_data = aged;
                rd_en   = 1'b1;
                rd_addr = idx_reg[PW-1:0] + PW'(1);
                if (idx_reg + CW'(1) >= n_act)
                    rd_addr = pick_reg;
            end
            ST_RUN:
            begin
                wr_en   = 1'b1;
                wr_addr = pick_reg;
                wr_data = fin;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            quantum_reg  <= 16'd2;
            aging_reg    <= 16'd5;
            maxp_reg     <= 8'd15;
            pcnt_reg     <= 5'd16;
            time_reg     <= '0;
            done_cnt_reg <= '0;
            idx_reg      <= '0;
            found_reg    <= 1'b0;
            for (int i = 0; i < MAX_PROCS; i++)
                pvalid_reg[i] <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_QUANTUM:  quantum_reg <= cfg_data;
                    REG_AGING:    aging_reg   <= cfg_data;
                    REG_MAX_PRIO: maxp_reg    <= cfg_data[7:0];
                    REG_PROC_CNT: pcnt_reg    <= cfg_data[4:0];
                    default: ;
                endcase
            end
            if (ld_proc)
            begin
                // drop a finished entry from the count when reloaded
                if (pvalid_reg[proc_index] && pk_done_flag(proc_index) && done_cnt_reg != '0)
                    done_cnt_reg <= done_cnt_reg - CW'(1);
                pvalid_reg[proc_index] <= 1'b1;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    idx_reg   <= '0;
                    found_reg <= 1'b0;
                end
                ST_SCAN:
                begin
                    if (ready_ent && (!found_reg || rel.prio > best_reg))
                        found_reg <= 1'b1;
                    idx_reg <= (idx_reg + CW'(1) >= n_act) ? '0 : idx_reg + CW'(1);
                end
                ST_AGE:
                begin
                    idx_reg <= idx_reg + CW'(1);
                    if (idx_reg + CW'(1) >= n_act && !found_reg)
                        time_reg <= time_reg + 32'd1;
                end
                ST_RUN:
                begin
                    time_reg <= time_reg + {16'd0, actual};
                    if (fin.done)
                        done_cnt_reg <= done_cnt_reg + CW'(1);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_PROCS; i++)
                done_ff_reg[i] <= 1'b0;
        end
        else if (ld_proc)
            done_ff_reg[proc_index] <= 1'b0;
        else if (state_reg == ST_RUN && fin.done)
            done_ff_reg[pick_reg] <= 1'b1;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SCAN && ready_ent && (!found_reg || rel.prio > best_reg))
        begin
            pick_reg <= idx_reg[PW-1:0];
            best_reg <= rel.prio;
        end
        if (state_reg == ST_IDLE)
            pick_reg <= '0;
        if (state_reg == ST_PICK_RD)
            pk_reg <= rd_reg;
        if (state_reg == ST_RUN || state_reg == ST_AGE || state_reg == ST_ALL_DONE)
        begin
            // the aging pass holds the idle slice; a run overwrites it
            idle         <= (state_reg == ST_AGE);
            all_done     <= state_reg == ST_ALL_DONE;
            chosen       <= (state_reg == ST_RUN) ? pick_reg : '0;
            slice_start  <= (state_reg == ST_ALL_DONE) ? '0 : time_reg;
            slice_length <= (state_reg == ST_RUN) ? actual :
                            (state_reg == ST_AGE) ? 16'd1 : '0;
            io_began     <= (state_reg == ST_RUN) && iob;
            io_length    <= (state_reg == ST_RUN) ? ioln : '0;
            completed    <= (state_reg == ST_RUN) && fin.done;
        end
    end

    logic res_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_reg <= 1'b0;
        else
            res_reg <= (state_reg == ST_ALL_DONE) || (state_reg == ST_RUN) ||
                       (state_reg == ST_AGE && idx_reg + CW'(1) >= n_act && !found_reg);
    end

    assign result_valid = res_reg;
    assign busy         = state_reg != ST_IDLE;
    assign cfg_ready    = state_reg == ST_IDLE;

    // checks
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid) else $error("result held two cycles");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done_cnt_reg <= CW'(MAX_PROCS)) else $error("done count overflow");
    a_run_found: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> found_reg) else $error("run without pick");

endmodule
